// ===== rtl/mcfe_pkg.sv =====
// Shared types and constants for the motor command frame encoder.
// No dependencies.
package mcfe_pkg;

  localparam int unsigned FrameMaxLen = 9;
  localparam int unsigned LenW        = 4;

  localparam logic [7:0] FRAME_HEADER  = 8'h7A;
  localparam logic [7:0] FRAME_TAIL    = 8'h7B;
  localparam logic [7:0] CODE_ENABLE   = 8'h06;
  localparam logic [7:0] CODE_MODE     = 8'h00;
  localparam logic [7:0] CODE_SPEED    = 8'h01;
  localparam logic [7:0] CODE_POSITION = 8'h02;
  localparam logic [7:0] CODE_QUERY    = 8'h0E;

  typedef enum logic [2:0] {
    OP_ENABLE   = 3'd0,
    OP_SET_MODE = 3'd1,
    OP_SET_SPD  = 3'd2,
    OP_SET_POS  = 3'd3,
    OP_QUERY    = 3'd4
  } op_e;

  // Built frame: bytes[0] goes out first.
  typedef struct packed {
    logic                        vld;
    logic [LenW-1:0]             len;
    logic [FrameMaxLen-1:0][7:0] bytes;
  } frame_t;

endpackage

// ===== rtl/mcfe_frame_build.sv =====
// Combinational frame builder: header, id, code, payload, XOR check, tail.
// Depends on mcfe_pkg.
module mcfe_frame_build import mcfe_pkg::*; (
  input  logic [2:0]  operation_i,
  input  logic [7:0]  node_id_i,
  input  logic [15:0] mode_i,
  input  logic [15:0] speed_i,
  input  logic [31:0] position_i,
  input  logic [7:0]  query_kind_i,
  output frame_t      frame_o
);

  logic [7:0]      code;
  logic [3:0][7:0] pay;   // pay[0] sent first
  logic [2:0]      plen;
  logic            ok;
  logic [7:0]      csum;

  always_comb begin
    code = CODE_ENABLE;
    pay  = '0;
    plen = 3'd0;
    ok   = 1'b1;
    unique case (operation_i)
      OP_ENABLE: begin
        code = CODE_ENABLE;
      end
      OP_SET_MODE: begin
        code   = CODE_MODE;
        pay[0] = mode_i[15:8];
        pay[1] = mode_i[7:0];
        plen   = 3'd2;
      end
      OP_SET_SPD: begin
        code   = CODE_SPEED;
        pay[0] = speed_i[15:8];
        pay[1] = speed_i[7:0];
        plen   = 3'd2;
      end
      OP_SET_POS: begin
        code   = CODE_POSITION;
        pay[0] = position_i[31:24];
        pay[1] = position_i[23:16];
        pay[2] = position_i[15:8];
        pay[3] = position_i[7:0];
        plen   = 3'd4;
      end
      OP_QUERY: begin
        code   = CODE_QUERY;
        pay[0] = query_kind_i;
        plen   = 3'd1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // unused payload bytes are zero, so they drop out of the XOR
  assign csum = FRAME_HEADER ^ node_id_i ^ code ^ pay[0] ^ pay[1] ^ pay[2] ^ pay[3];

  always_comb begin
    frame_o          = '0;
    frame_o.vld      = ok;
    frame_o.len      = LenW'(plen) + LenW'(5);
    frame_o.bytes[0] = FRAME_HEADER;
    frame_o.bytes[1] = node_id_i;
    frame_o.bytes[2] = code;
    for (int k = 0; k < 6; k++) begin
      if (3'(k) < plen) begin
        frame_o.bytes[k+3] = pay[k[1:0]];
      end else if (3'(k) == plen) begin
        frame_o.bytes[k+3] = csum;
      end else if (3'(k) == plen + 3'd1) begin
        frame_o.bytes[k+3] = FRAME_TAIL;
      end
    end
  end

endmodule

// ===== rtl/motor_command_frame_encoder_unit.sv =====
// Motor command frame encoder: one command in, one serial frame of 5..9 bytes out.
// The first frame byte passes through the frame shift register and then the output register.
// Throughput: one byte per cycle while m_axis_tready holds; the next command is taken
// as the tail byte of the current frame (5, 6, 7 or 9 bytes) leaves the frame shift register.
// Reset: asynchronous, active low; clears the frame valid flag, byte count and output valid flag only.
// Depends on mcfe_pkg and mcfe_frame_build.
module motor_command_frame_encoder_unit import mcfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] node id, [23:8] mode, [39:24] speed, [71:40] position, [79:72] query_kind
  input  logic [79:0] s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser,
  // frame byte request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  frame_t                      built;

  // frame shift register: bytes_q[0] is the next byte to go out
  logic                        frm_vld_q, frm_vld_d;
  logic [LenW-1:0]             rem_q, rem_d;
  logic [FrameMaxLen-1:0][7:0] bytes_q, bytes_d;

  // output register, parts the frame store from the downstream stall
  logic                        out_vld_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;

  logic out_load, take, frm_done, in_acc;

  mcfe_frame_build u_build (
    .operation_i  (s_axis_tuser),
    .node_id_i    (s_axis_tdata[7:0]),
    .mode_i       (s_axis_tdata[23:8]),
    .speed_i      (s_axis_tdata[39:24]),
    .position_i   (s_axis_tdata[71:40]),
    .query_kind_i (s_axis_tdata[79:72]),
    .frame_o      (built)
  );

  assign out_load = !out_vld_q || m_axis_tready;
  assign take     = out_load && frm_vld_q;
  assign frm_done = take && (rem_q == LenW'(1));

  // a new command loads while the tail byte of the previous one moves out
  assign s_axis_tready = !frm_vld_q || frm_done;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    frm_vld_d = frm_vld_q;
    rem_d     = rem_q;
    bytes_d   = bytes_q;
    if (in_acc) begin
      // unused operation codes are taken and give no frame
      frm_vld_d = built.vld;
      rem_d     = built.len;
      bytes_d   = built.bytes;
    end else if (take) begin
      frm_vld_d = !frm_done;
      rem_d     = rem_q - LenW'(1);
      bytes_d   = {8'h00, bytes_q[FrameMaxLen-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_vld_q <= 1'b0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      frm_vld_q <= frm_vld_d;
      rem_q     <= rem_d;
      if (out_load) begin
        out_vld_q <= frm_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (out_load) begin
      out_byte_q <= bytes_q[0];
      out_last_q <= (rem_q == LenW'(1));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // frame store never holds more than a longest frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_vld_q |-> (rem_q != '0) && (rem_q <= LenW'(FrameMaxLen)))
    else $error("frame byte count out of range");

  // a command is only taken when the store is empty or its tail is leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!frm_vld_q || (take && rem_q == LenW'(1))))
    else $error("command taken over a frame still in flight");

  // every byte marked last is the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == FRAME_TAIL))
    else $error("last byte is not the frame tail");

  // a freshly loaded frame has one of the legal lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && built.vld) |=> (rem_q == LenW'(5) || rem_q == LenW'(6) ||
                               rem_q == LenW'(7) || rem_q == LenW'(9)))
    else $error("illegal frame length loaded");

endmodule
